/* hw/rtl/dcd_pkg.sv */
// Shared types and constants for the directed cycle detector.
// Used by dcd_edge_store, directed_cycle_detector and the testbench; depends on nothing.
`timescale 1ns / 1ps

package dcd_pkg;

   localparam int DEF_MAX_VERTICES = 256;
   localparam int DEF_MAX_EDGES    = 1024;

   localparam int COUNT_W  = 9;
   localparam int VTX_W    = 8;
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   typedef enum logic [1:0] {
      WHITE = 2'd0,
      GRAY  = 2'd1,
      BLACK = 2'd2
   } color_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_LOAD,
      S_SETTLE,
      W_ROOT,
      W_ROOT_CHK,
      W_EDGE,
      W_POP,
      W_TGT,
      W_VIS,
      S_RESULT
   } state_type;

   // load control from the sequencer to the edge store
   typedef struct packed {
      logic take;
      logic carries_edge;
      logic restart;
   } ld_ctl_type;

endpackage

/* hw/rtl/dcd_edge_store.sv */
// Edge store: per-vertex list heads and the linked edge table, with load checks.
// Depends on dcd_pkg.
`timescale 1ns / 1ps

module dcd_edge_store #(
   parameter int MAX_VERTICES = dcd_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = dcd_pkg::DEF_MAX_EDGES,
   localparam int VW  = $clog2(MAX_VERTICES),
   localparam int VCW = $clog2(MAX_VERTICES + 1),
   localparam int EIW = $clog2(MAX_EDGES),
   localparam int HW  = $clog2(MAX_EDGES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcd_pkg::ld_ctl_type           ld,
   input  logic [dcd_pkg::VTX_W-1:0]     from_vertex,
   input  logic [dcd_pkg::VTX_W-1:0]     to_vertex,
   input  logic [VCW-1:0]                used_count,
   input  logic                          clr_we,
   input  logic [VW-1:0]                 clr_addr,
   input  logic [VW-1:0]                 head_raddr,
   input  logic [EIW-1:0]                edge_raddr,
   output logic [HW-1:0]                 head_rdata,
   output logic [VW-1:0]                 tgt_rdata,
   output logic [HW-1:0]                 next_rdata,
   output logic [dcd_pkg::STATUS_W-1:0]  load_err
);

   localparam logic [HW-1:0] NO_EDGE = HW'(MAX_EDGES);

   logic [HW-1:0] head_mem [MAX_VERTICES];
   logic [VW-1:0] tgt_mem  [MAX_EDGES];
   logic [HW-1:0] next_mem [MAX_EDGES];

   logic [HW-1:0]                edges_ff, edges_in;
   logic [dcd_pkg::STATUS_W-1:0] err_ff, err_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [VW-1:0]                s1_from_ff, s1_to_ff;
   logic [EIW-1:0]               s1_idx_ff;
   logic                         fw_valid_ff;
   logic [VW-1:0]                fw_from_ff;
   logic [EIW-1:0]               fw_idx_ff;
   logic [HW-1:0]                head_rd_ff, tgt_next;
   logic [VW-1:0]                tgt_rd_ff;
   logic [HW-1:0]                next_rd_ff;
   logic                         bad, full, store;
   logic                         head_we;
   logic [VW-1:0]                head_waddr, head_ra;
   logic [HW-1:0]                head_wdata;

   // check the word, count the edge and keep the first error
   always_comb begin
      bad   = (32'(from_vertex) >= 32'(used_count)) || (32'(to_vertex) >= 32'(used_count));
      full  = (edges_ff == NO_EDGE);
      store = ld.take && ld.carries_edge && !bad && !full;
      edges_in    = edges_ff;
      err_in      = err_ff;
      s1_valid_in = store;
      if (ld.restart) begin
         edges_in = '0;
         err_in   = dcd_pkg::ST_OK;
      end else if (ld.take && ld.carries_edge) begin
         if (bad) begin
            if (err_ff == dcd_pkg::ST_OK) err_in = dcd_pkg::ST_RANGE;
         end else if (full) begin
            if (err_ff == dcd_pkg::ST_OK) err_in = dcd_pkg::ST_OVERFLOW;
         end else begin
            edges_in = edges_ff + HW'(1);
         end
      end
   end

   // forward the head written for the edge just ahead in the pipeline when the same source repeats
   always_comb begin
      tgt_next = (fw_valid_ff && fw_from_ff == s1_from_ff) ? HW'(fw_idx_ff) : head_rd_ff;
      head_we    = clr_we || s1_valid_ff;
      head_waddr = clr_we ? clr_addr : s1_from_ff;
      head_wdata = clr_we ? NO_EDGE : HW'(s1_idx_ff);
      head_ra    = ld.take ? VW'(from_vertex) : head_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff    <= '0;
         err_ff      <= dcd_pkg::ST_OK;
         s1_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         edges_ff    <= edges_in;
         err_ff      <= err_in;
         s1_valid_ff <= s1_valid_in;
         fw_valid_ff <= s1_valid_ff;
      end
      s1_from_ff <= VW'(from_vertex);
      s1_to_ff   <= VW'(to_vertex);
      s1_idx_ff  <= edges_ff[EIW-1:0];
      fw_from_ff <= s1_from_ff;
      fw_idx_ff  <= s1_idx_ff;
   end

   // list head memory
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[head_ra];
   end

   // edge table memories
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         tgt_mem[s1_idx_ff]  <= s1_to_ff;
         next_mem[s1_idx_ff] <= tgt_next;
      end
      tgt_rd_ff  <= tgt_mem[edge_raddr];
      next_rd_ff <= next_mem[edge_raddr];
   end

   assign head_rdata = head_rd_ff;
   assign tgt_rdata  = tgt_rd_ff;
   assign next_rdata = next_rd_ff;
   assign load_err   = err_ff;

endmodule

/* hw/rtl/directed_cycle_detector.sv */
// Directed cycle detector: loads edges one word per unstalled cycle, then walks the graph.
// Result to next graph: a clearing pass over every vertex's color and list head, input stalled.
// Reset (synchronous): vertex_count = 256, then the same clearing pass runs.
// Depends on dcd_pkg and dcd_edge_store.
`timescale 1ns / 1ps

module directed_cycle_detector #(
   parameter int MAX_VERTICES = dcd_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = dcd_pkg::DEF_MAX_EDGES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dcd_pkg::VTX_W-1:0]     req_from_vertex,
   input  logic [dcd_pkg::VTX_W-1:0]     req_to_vertex,
   input  logic                          req_carries_edge,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_cycle_found,
   output logic [dcd_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dcd_pkg::COUNT_W-1:0]   csr_data
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int HW  = $clog2(MAX_EDGES + 1);
   localparam int SW  = VW + HW;

   dcd_pkg::state_type state_ff, state_in;

   logic [dcd_pkg::COUNT_W-1:0]  count_ff;
   logic [VCW-1:0]               used_n;
   logic [VW-1:0]                clr_ff, clr_in;
   logic [VCW-1:0]               root_ff, root_in;
   logic [VCW-1:0]               depth_ff, depth_in;
   logic [VW-1:0]                top_v_ff, top_v_in;
   logic [HW-1:0]                top_cur_ff, top_cur_in;
   logic [VW-1:0]                tv_ff, tv_in;
   logic                         found_ff, found_in;
   logic [dcd_pkg::STATUS_W-1:0] pstat_ff, pstat_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic [dcd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         res_load;

   dcd_pkg::color_type color_mem [MAX_VERTICES];
   dcd_pkg::color_type color_rd_ff, color_wdata;
   logic               color_we;
   logic [VW-1:0]      color_waddr, color_raddr;

   logic [SW-1:0]      stack_mem [MAX_VERTICES];
   logic [SW-1:0]      stack_rd_ff;
   logic               stack_we;
   logic [VW-1:0]      stack_waddr, stack_raddr;

   dcd_pkg::ld_ctl_type          ld;
   logic                         accept;
   logic [VW-1:0]                head_raddr;
   logic [EIW-1:0]               edge_raddr;
   logic [HW-1:0]                head_rdata, next_rdata;
   logic [VW-1:0]                tgt_rdata;
   logic [dcd_pkg::STATUS_W-1:0] load_err;

   // vertices in use, capped at the table size
   assign used_n = (32'(count_ff) > MAX_VERTICES) ? VCW'(MAX_VERTICES) : VCW'(count_ff);

   assign req_stall = (state_ff != dcd_pkg::S_LOAD);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   dcd_edge_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld),
      .from_vertex (req_from_vertex),
      .to_vertex   (req_to_vertex),
      .used_count  (used_n),
      .clr_we      (state_ff == dcd_pkg::S_CLEAR),
      .clr_addr    (clr_ff),
      .head_raddr  (head_raddr),
      .edge_raddr  (edge_raddr),
      .head_rdata  (head_rdata),
      .tgt_rdata   (tgt_rdata),
      .next_rdata  (next_rdata),
      .load_err    (load_err)
   );

   // sequencer: clear, load, settle, walk (skipped on a load error), report
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      root_in      = root_ff;
      depth_in     = depth_ff;
      top_v_in     = top_v_ff;
      top_cur_in   = top_cur_ff;
      tv_in        = tv_ff;
      found_in     = found_ff;
      pstat_in     = pstat_ff;
      res_load     = 1'b0;
      ld.take         = accept;
      ld.carries_edge = req_carries_edge;
      ld.restart      = 1'b0;
      color_we     = 1'b0;
      color_waddr  = top_v_ff;
      color_wdata  = dcd_pkg::WHITE;
      color_raddr  = root_ff[VW-1:0];
      stack_we     = 1'b0;
      stack_waddr  = VW'(depth_ff - VCW'(1));
      stack_raddr  = VW'(depth_ff - VCW'(2));
      head_raddr   = root_ff[VW-1:0];
      edge_raddr   = top_cur_ff[EIW-1:0];
      case (state_ff)
         dcd_pkg::S_CLEAR: begin
            ld.restart  = 1'b1;
            color_we    = 1'b1;
            color_waddr = clr_ff;
            color_wdata = dcd_pkg::WHITE;
            clr_in      = clr_ff + VW'(1);
            if (clr_ff == VW'(MAX_VERTICES - 1)) begin
               clr_in   = '0;
               state_in = dcd_pkg::S_LOAD;
            end
         end
         dcd_pkg::S_LOAD: begin
            if (accept && req_is_last) state_in = dcd_pkg::S_SETTLE;
         end
         dcd_pkg::S_SETTLE: begin
            found_in = 1'b0;
            pstat_in = load_err;
            root_in  = '0;
            state_in = (load_err != dcd_pkg::ST_OK) ? dcd_pkg::S_RESULT : dcd_pkg::W_ROOT;
         end
         dcd_pkg::W_ROOT: begin
            if (root_ff >= used_n) begin
               state_in = dcd_pkg::S_RESULT;
            end else begin
               state_in = dcd_pkg::W_ROOT_CHK;
            end
         end
         dcd_pkg::W_ROOT_CHK: begin
            if (color_rd_ff == dcd_pkg::WHITE) begin
               color_we    = 1'b1;
               color_waddr = root_ff[VW-1:0];
               color_wdata = dcd_pkg::GRAY;
               top_v_in    = root_ff[VW-1:0];
               top_cur_in  = head_rdata;
               depth_in    = VCW'(1);
               state_in    = dcd_pkg::W_EDGE;
            end else begin
               root_in  = root_ff + VCW'(1);
               state_in = dcd_pkg::W_ROOT;
            end
         end
         dcd_pkg::W_EDGE: begin
            if (top_cur_ff >= HW'(MAX_EDGES)) begin
               // list done: finish the vertex and pop
               color_we    = 1'b1;
               color_waddr = top_v_ff;
               color_wdata = dcd_pkg::BLACK;
               depth_in    = depth_ff - VCW'(1);
               if (depth_ff == VCW'(1)) begin
                  root_in  = root_ff + VCW'(1);
                  state_in = dcd_pkg::W_ROOT;
               end else begin
                  state_in = dcd_pkg::W_POP;
               end
            end else begin
               state_in = dcd_pkg::W_TGT;
            end
         end
         dcd_pkg::W_POP: begin
            top_v_in   = stack_rd_ff[SW-1:HW];
            top_cur_in = stack_rd_ff[HW-1:0];
            state_in   = dcd_pkg::W_EDGE;
         end
         dcd_pkg::W_TGT: begin
            top_cur_in  = next_rdata;
            tv_in       = tgt_rdata;
            color_raddr = tgt_rdata;
            head_raddr  = tgt_rdata;
            state_in    = dcd_pkg::W_VIS;
         end
         dcd_pkg::W_VIS: begin
            state_in = dcd_pkg::W_EDGE;
            if (color_rd_ff == dcd_pkg::GRAY) begin
               found_in = 1'b1;
               state_in = dcd_pkg::S_RESULT;
            end else if (color_rd_ff == dcd_pkg::WHITE &&
                         32'(depth_ff) < MAX_VERTICES) begin
               // push the current frame and descend
               stack_we    = 1'b1;
               color_we    = 1'b1;
               color_waddr = tv_ff;
               color_wdata = dcd_pkg::GRAY;
               top_v_in    = tv_ff;
               top_cur_in  = head_rdata;
               depth_in    = depth_ff + VCW'(1);
            end
         end
         dcd_pkg::S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               res_load = 1'b1;
               clr_in   = '0;
               state_in = dcd_pkg::S_CLEAR;
            end
         end
         default: begin
            state_in = dcd_pkg::S_CLEAR;
         end
      endcase
   end

   // hold the result word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (res_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcd_pkg::S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= dcd_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) count_ff <= csr_data;
      end
      root_ff    <= root_in;
      depth_ff   <= depth_in;
      top_v_ff   <= top_v_in;
      top_cur_ff <= top_cur_in;
      tv_ff      <= tv_in;
      found_ff   <= found_in;
      pstat_ff   <= pstat_in;
      if (res_load) begin
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= pstat_ff;
      end
   end

   // vertex color memory
   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[color_waddr] <= color_wdata;
      end
      color_rd_ff <= color_mem[color_raddr];
   end

   // walk stack memory: frames below the top
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= {top_v_ff, top_cur_ff};
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cycle_found = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* dv/tb_directed_cycle_detector.sv */
// Testbench for directed_cycle_detector: drives edge words, predicts cycle/status per graph.
// Depends on dcd_pkg and the directed_cycle_detector RTL.
`timescale 1ns / 1ps

module tb_directed_cycle_detector;

   localparam int NV = dcd_pkg::DEF_MAX_VERTICES;
   localparam int NE = dcd_pkg::DEF_MAX_EDGES;

   typedef struct packed {
      logic                         cycle_found;
      logic [dcd_pkg::STATUS_W-1:0] status;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [dcd_pkg::VTX_W-1:0] req_from_vertex = '0;
   logic [dcd_pkg::VTX_W-1:0] req_to_vertex = '0;
   logic req_carries_edge = 1'b0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_cycle_found;
   logic [dcd_pkg::STATUS_W-1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dcd_pkg::COUNT_W-1:0] csr_data = '0;

   directed_cycle_detector dut (.*);

   // graph mirror
   logic [dcd_pkg::COUNT_W-1:0]  vtx_count;
   dcd_pkg::color_type           shade[NV];
   int                           head[NV];
   int                           tgt[NE];
   int                           nxt[NE];
   int                           n_edges;
   logic [dcd_pkg::STATUS_W-1:0] load_err;
   int                           frame_v[NV];
   int                           frame_c[NV];

   verdict_type verdicts[$];
   int   fail_count = 0;
   bit   gaps_on = 1'b1;
   bit   hold_rsp = 1'b0;

   initial forever #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic void clear_graph();
      for (int i = 0; i < NV; i++) begin
         shade[i] = dcd_pkg::WHITE;
         head[i] = NE;
      end
      n_edges = 0;
      load_err = dcd_pkg::ST_OK;
   endfunction

   function automatic bit walk_finds_cycle(input int root);
      int depth, e, t;
      shade[root] = dcd_pkg::GRAY;
      frame_v[0] = root;
      frame_c[0] = head[root];
      depth = 1;
      while (depth > 0) begin
         e = frame_c[depth-1];
         if (e >= NE) begin
            shade[frame_v[depth-1]] = dcd_pkg::BLACK;
            depth--;
            continue;
         end
         frame_c[depth-1] = nxt[e];
         t = tgt[e] % NV;
         if (shade[t] == dcd_pkg::GRAY) return 1'b1;
         if (shade[t] == dcd_pkg::WHITE && depth < NV) begin
            shade[t] = dcd_pkg::GRAY;
            frame_v[depth] = t;
            frame_c[depth] = head[t];
            depth++;
         end
      end
      return 1'b0;
   endfunction

   // advance the mirror by one word; queue a verdict on the last word
   function automatic void predict_word(input int f, input int t, input bit has_e,
                                        input bit last);
      int n;
      verdict_type v;
      n = (vtx_count > NV) ? NV : vtx_count;
      if (has_e) begin
         if (f >= n || t >= n) begin
            if (load_err == dcd_pkg::ST_OK) load_err = dcd_pkg::ST_RANGE;
         end else if (n_edges >= NE) begin
            if (load_err == dcd_pkg::ST_OK) load_err = dcd_pkg::ST_OVERFLOW;
         end else begin
            tgt[n_edges] = t;
            nxt[n_edges] = head[f];
            head[f] = n_edges;
            n_edges++;
         end
      end
      if (!last) return;
      v.status = load_err;
      v.cycle_found = 1'b0;
      if (load_err == dcd_pkg::ST_OK)
         for (int i = 0; i < n; i++)
            if (shade[i] == dcd_pkg::WHITE && walk_finds_cycle(i)) begin
               v.cycle_found = 1'b1;
               break;
            end
      verdicts = {verdicts, v};
      clear_graph();
   endfunction

   // offer one word; valid stays high into the next word unless a gap follows
   task automatic send_word(input int f, input int t, input bit has_e, input bit last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_from_vertex <= dcd_pkg::VTX_W'(f);
      req_to_vertex <= dcd_pkg::VTX_W'(t);
      req_carries_edge <= has_e;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(f, t, has_e, last);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (verdicts.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      // let the clearing pass finish
      repeat (NV + 50) @(posedge clock);
   endtask

   task automatic write_count(input int value);
      csr_valid <= 1'b1;
      csr_data <= dcd_pkg::COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      vtx_count = dcd_pkg::COUNT_W'(value);
   endtask

   task automatic random_graph(input int n, input int edges, input bit in_range);
      int m;
      m = (n > NV) ? NV : n;
      for (int i = 0; i < edges; i++)
         if (in_range || $urandom_range(0, 9) != 0)
            send_word($urandom_range(0, m - 1), $urandom_range(0, m - 1), 1'b1, 1'b0);
         else
            send_word($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                      1'b0);
      send_word($urandom_range(0, m - 1), $urandom_range(0, m - 1), $urandom_range(0, 1),
                1'b1);
   endtask

   task automatic test_directed();
      write_count(4);
      send_word(0, 1, 1, 0); send_word(1, 2, 1, 0); send_word(2, 0, 1, 1);   // ring
      send_word(0, 1, 1, 0); send_word(1, 2, 1, 0); send_word(0, 2, 1, 1);   // dag
      send_word(3, 3, 1, 1);                                                 // self loop
      send_word(0, 0, 0, 1);                                                 // bare end marker
      send_word(4, 0, 1, 0); send_word(0, 0, 1, 1);                          // bad vertex
      drain();
      write_count(NV);
      send_word(255, 0, 1, 0); send_word(0, 255, 1, 1);
      send_word(170, 85, 1, 0); send_word(85, 170, 1, 1);
      drain();
      write_count(511);                                                      // oversized count
      send_word(200, 255, 1, 1);
      drain();
      write_count(0);
      send_word(0, 0, 1, 0); send_word(0, 0, 0, 1);
      drain();
      write_count(1);
      send_word(0, 0, 0, 1);
      send_word(0, 0, 1, 1);
      drain();
      // count changed while loading: stored edges kept, walk uses final count
      write_count(8);
      send_word(6, 7, 1, 0); send_word(7, 6, 1, 0);
      drain();
      write_count(3);
      send_word(0, 1, 1, 1);
      drain();
   endtask

   // dense lists on a few vertices, with a range error after many stored edges
   task automatic test_dense();
      write_count(16);
      for (int i = 0; i < 48; i++) send_word(i % 16, (i + 5) % 16, 1, 0);
      send_word(0, 99, 1, 0);
      send_word(0, 1, 1, 1);
      for (int i = 0; i <= 10; i++) send_word($urandom_range(0, 15), $urandom_range(0, 15),
                                             1, i == 10);
      drain();
   endtask

   task automatic test_random();
      int sizes[4] = '{2, 5, 12, 40};
      int n;
      for (int g = 0; g < 30; g++) begin
         n = sizes[$urandom_range(0, 3)];
         write_count(n);
         random_graph(n, $urandom_range(0, 8), $urandom_range(0, 3) != 0);
         random_graph(n, $urandom_range(0, 3), 1'b1);
         drain();
      end
   endtask

   task automatic test_backpressure();
      write_count(6);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int g = 0; g < 6; g++) random_graph(6, 3, 1'b1);
      join
      drain();
      gaps_on = 1'b0;
      write_count(256);
      for (int g = 0; g < 10; g++) random_graph(256, 6, 1'b1);
      drain();
   endtask

   // receiver stall generator
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_stall <= 1'b1;
         else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else rsp_stall <= 1'b0;
      end
   end

   // compare each accepted verdict
   initial begin
      verdict_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (verdicts.size() == 0) report("unexpected verdict", rsp_status, -1);
            else begin
               want = verdicts.pop_front();
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
               if (rsp_cycle_found !== want.cycle_found)
                  report("cycle_found", rsp_cycle_found, want.cycle_found);
            end
         end
      end
   end

   initial begin
      vtx_count = dcd_pkg::COUNT_RESET;
      clear_graph();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (NV + 20) @(posedge clock);
      test_directed();
      test_dense();
      test_random();
      test_backpressure();
      drain();
      if (fail_count == 0 && verdicts.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/dcd_pkg.sv
hw/rtl/dcd_edge_store.sv
hw/rtl/directed_cycle_detector.sv
dv/tb_directed_cycle_detector.sv
